// File: hdl/nqb_pkg.sv
// ----------------------------------------------------------------------------
// nqb_pkg
// Shared sizes, microcode word layout, opcodes and the sequencer program of
// the N-queens backtracking solver.
// ----------------------------------------------------------------------------
package nqb_pkg;

	// board limits
	localparam int MAX_N      = 16;
	localparam int IDX_W      = 4;              // column / row index width
	localparam int CNT_W      = 5;              // counter width, holds MAX_N
	localparam int DIAG_N     = 2 * MAX_N - 1;
	localparam int DIAG_BIAS  = MAX_N - 1;
	localparam int SIZE_W     = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

	// microcode step counter
	localparam int UPC_W = 5;

	// datapath operations
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_ACCEPT    = 4'd1;
	localparam logic [3:0] OP_NEXT_ROW  = 4'd2;
	localparam logic [3:0] OP_PLACE     = 4'd3;
	localparam logic [3:0] OP_BT_READ   = 4'd4;
	localparam logic [3:0] OP_BT_LOAD   = 4'd5;
	localparam logic [3:0] OP_BT_UNMARK = 4'd6;
	localparam logic [3:0] OP_OUT_INIT  = 4'd7;
	localparam logic [3:0] OP_OUT_READ  = 4'd8;
	localparam logic [3:0] OP_EMIT      = 4'd9;
	localparam logic [3:0] OP_EMIT_FAIL = 4'd10;

	// jump conditions
	localparam logic [2:0] C_ALWAYS   = 3'd0;
	localparam logic [2:0] C_START    = 3'd1;
	localparam logic [2:0] C_COL_DONE = 3'd2;
	localparam logic [2:0] C_ROW_DONE = 3'd3;
	localparam logic [2:0] C_COL_ZERO = 3'd4;
	localparam logic [2:0] C_FREE     = 3'd5;
	localparam logic [2:0] C_OUT_FREE = 3'd6;
	localparam logic [2:0] C_LAST     = 3'd7;

	// program entry points
	localparam logic [UPC_W-1:0] S_IDLE  = UPC_W'(0);
	localparam logic [UPC_W-1:0] S_LOOP  = UPC_W'(1);
	localparam logic [UPC_W-1:0] S_PLACE = UPC_W'(5);
	localparam logic [UPC_W-1:0] S_BACK  = UPC_W'(6);
	localparam logic [UPC_W-1:0] S_SUCC  = UPC_W'(10);
	localparam logic [UPC_W-1:0] S_OUT   = UPC_W'(11);
	localparam logic [UPC_W-1:0] S_WAIT  = UPC_W'(12);
	localparam logic [UPC_W-1:0] S_FAIL  = UPC_W'(15);

	// one control word: operation, jump condition (optionally inverted), target
	typedef struct packed {
		logic [3:0]       op;
		logic [2:0]       cond;
		logic             inv;
		logic [UPC_W-1:0] target;
	} uword_t;

	function automatic uword_t uw(input logic [3:0] op, input logic [2:0] cond,
			input logic inv, input logic [UPC_W-1:0] target);
		uword_t w;
		w.op     = op;
		w.cond   = cond;
		w.inv    = inv;
		w.target = target;
		return w;
	endfunction

	// sequencer program; a fall-through step jumps on "never" (always, inverted)
	function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
		uword_t w;
		unique case (upc)
			5'd0:    w = uw(OP_ACCEPT,    C_START,    1'b1, S_IDLE);
			5'd1:    w = uw(OP_NOP,       C_COL_DONE, 1'b0, S_SUCC);
			5'd2:    w = uw(OP_NOP,       C_ROW_DONE, 1'b0, S_BACK);
			5'd3:    w = uw(OP_NOP,       C_FREE,     1'b0, S_PLACE);
			5'd4:    w = uw(OP_NEXT_ROW,  C_ALWAYS,   1'b0, S_LOOP);
			5'd5:    w = uw(OP_PLACE,     C_ALWAYS,   1'b0, S_LOOP);
			5'd6:    w = uw(OP_NOP,       C_COL_ZERO, 1'b0, S_FAIL);
			5'd7:    w = uw(OP_BT_READ,   C_ALWAYS,   1'b1, S_IDLE);
			5'd8:    w = uw(OP_BT_LOAD,   C_ALWAYS,   1'b1, S_IDLE);
			5'd9:    w = uw(OP_BT_UNMARK, C_ALWAYS,   1'b0, S_LOOP);
			5'd10:   w = uw(OP_OUT_INIT,  C_ALWAYS,   1'b1, S_IDLE);
			5'd11:   w = uw(OP_OUT_READ,  C_ALWAYS,   1'b1, S_IDLE);
			5'd12:   w = uw(OP_NOP,       C_OUT_FREE, 1'b1, S_WAIT);
			5'd13:   w = uw(OP_EMIT,      C_LAST,     1'b0, S_IDLE);
			5'd14:   w = uw(OP_NOP,       C_ALWAYS,   1'b0, S_OUT);
			5'd15:   w = uw(OP_NOP,       C_OUT_FREE, 1'b1, S_FAIL);
			5'd16:   w = uw(OP_EMIT_FAIL, C_ALWAYS,   1'b0, S_IDLE);
			default: w = uw(OP_NOP,       C_ALWAYS,   1'b0, S_IDLE);
		endcase
		return w;
	endfunction

endpackage

// File: hdl/nqb_start_if.sv
// ----------------------------------------------------------------------------
// nqb_start_if
// Start request channel: one beat with start_req set asks for one search.
// ----------------------------------------------------------------------------
interface nqb_start_if;
	logic valid;
	logic ready;
	logic start_req;

	modport source (output valid, output start_req, input ready);
	modport sink (input valid, input start_req, output ready);
endinterface

// File: hdl/nqb_result_if.sv
// ----------------------------------------------------------------------------
// nqb_result_if
// Result channel: one beat per board column, or one failure beat.
// ----------------------------------------------------------------------------
interface nqb_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] column;
	logic [3:0] queen_row;
	logic       found;
	logic       last;

	modport source (output valid, output column, output queen_row, output found,
		output last, input ready);
	modport sink (input valid, input column, input queen_row, input found,
		input last, output ready);
endinterface

// File: hdl/nqb_cfg_if.sv
// ----------------------------------------------------------------------------
// nqb_cfg_if
// Configuration write channel carrying the board size register.
// ----------------------------------------------------------------------------
interface nqb_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] board_size;

	modport source (output valid, output board_size, input ready);
	modport sink (input valid, input board_size, output ready);
endinterface

// File: hdl/nqb_ram.sv
// ----------------------------------------------------------------------------
// nqb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nqb_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/n_queens_backtrack_solver_core.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_core
// Depth-first N-queens search run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A start beat with start_req=1 runs one search on an N by N board, N being
// the board_size register clamped to 1..16 (reset 8); a beat with start_req=0
// is taken and ignored. The first placement in column-major, ascending-row
// order is reported as N result beats, column 0 first, last marked; an
// unsolvable board gives one beat with found=0. A sequencer steps one control
// word per clock: a trial tests column, row and square, then places the queen
// or moves to the next row; a backtrack steps back a column, reads its row
// from the placed-row store's registered read port, then unmarks it and tries
// the next row. Each result beat waits for the output register to be free.
// ----------------------------------------------------------------------------
module n_queens_backtrack_solver_core
	import nqb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	nqb_cfg_if.sink      cfg,
	nqb_start_if.sink    start,
	nqb_result_if.source result
);

	// sequencer
	logic [UPC_W-1:0] upc_q;
	uword_t           uw_cur;
	logic             cond_hit;
	logic             take_jump;

	// search datapath
	logic [SIZE_W-1:0] board_size_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  n_sat;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  trow_q;
	logic [MAX_N-1:0]  rows_q;
	logic [DIAG_N-1:0] ddown_q;
	logic [DIAG_N-1:0] dup_q;
	logic [CNT_W-1:0]  ddown_idx;
	logic [CNT_W-1:0]  dup_idx;
	logic [MAX_N-1:0]  row_bit;
	logic [DIAG_N-1:0] ddown_bit;
	logic [DIAG_N-1:0] dup_bit;
	logic              sq_free;

	// placed-row store
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] ram_rdata;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_column_q;
	logic [IDX_W-1:0] out_row_q;
	logic             out_found_q;
	logic             out_last_q;
	logic             out_free;

	// fetch control word
	assign uw_cur = ucode_rom(upc_q);

	// take configuration beats at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			board_size_q <= cfg.board_size;
		end
	end

	// clamp board size to 1..MAX_N
	always_comb begin
		if (board_size_q == '0) begin
			n_sat = CNT_W'(1);
		end else if (board_size_q > SIZE_W'(MAX_N)) begin
			n_sat = CNT_W'(MAX_N);
		end else begin
			n_sat = board_size_q;
		end
	end

	// square masks for the trial square
	assign ddown_idx = {1'b0, trow_q[IDX_W-1:0]} + CNT_W'(DIAG_BIAS)
		- {1'b0, col_q[IDX_W-1:0]};
	assign dup_idx   = {1'b0, trow_q[IDX_W-1:0]} + {1'b0, col_q[IDX_W-1:0]};
	assign row_bit   = MAX_N'(1) << trow_q[IDX_W-1:0];
	assign ddown_bit = DIAG_N'(1) << ddown_idx;
	assign dup_bit   = DIAG_N'(1) << dup_idx;
	assign sq_free   = ((rows_q & row_bit) == '0) && ((ddown_q & ddown_bit) == '0)
		&& ((dup_q & dup_bit) == '0);

	assign out_free = !out_valid_q || result.ready;

	// evaluate jump condition
	always_comb begin
		unique case (uw_cur.cond)
			C_ALWAYS:   cond_hit = 1'b1;
			C_START:    cond_hit = start.valid && start.start_req;
			C_COL_DONE: cond_hit = col_q >= n_q;
			C_ROW_DONE: cond_hit = trow_q >= n_q;
			C_COL_ZERO: cond_hit = col_q == '0;
			C_FREE:     cond_hit = sq_free;
			C_OUT_FREE: cond_hit = out_free;
			C_LAST:     cond_hit = (col_q + CNT_W'(1)) == n_q;
			default:    cond_hit = 1'b0;
		endcase
	end

	assign take_jump = cond_hit ^ uw_cur.inv;

	// advance step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else if (take_jump) begin
			upc_q <= uw_cur.target;
		end else begin
			upc_q <= upc_q + UPC_W'(1);
		end
	end

	assign start.ready = uw_cur.op == OP_ACCEPT;

	// search datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= CNT_W'(1);
			col_q   <= '0;
			trow_q  <= '0;
			rows_q  <= '0;
			ddown_q <= '0;
			dup_q   <= '0;
		end else begin
			unique case (uw_cur.op)
				OP_ACCEPT: begin
					if (start.valid && start.start_req) begin
						n_q     <= n_sat;
						col_q   <= '0;
						trow_q  <= '0;
						rows_q  <= '0;
						ddown_q <= '0;
						dup_q   <= '0;
					end
				end
				OP_NEXT_ROW: begin
					trow_q <= trow_q + CNT_W'(1);
				end
				OP_PLACE: begin
					rows_q  <= rows_q ^ row_bit;
					ddown_q <= ddown_q ^ ddown_bit;
					dup_q   <= dup_q ^ dup_bit;
					col_q   <= col_q + CNT_W'(1);
					trow_q  <= '0;
				end
				OP_BT_READ: begin
					col_q <= col_q - CNT_W'(1);
				end
				OP_BT_LOAD: begin
					trow_q <= {1'b0, ram_rdata};
				end
				OP_BT_UNMARK: begin
					rows_q  <= rows_q ^ row_bit;
					ddown_q <= ddown_q ^ ddown_bit;
					dup_q   <= dup_q ^ dup_bit;
					trow_q  <= trow_q + CNT_W'(1);
				end
				OP_OUT_INIT: begin
					col_q <= '0;
				end
				OP_EMIT: begin
					col_q <= col_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// placed-row store ports
	assign ram_we    = uw_cur.op == OP_PLACE;
	assign ram_re    = (uw_cur.op == OP_BT_READ) || (uw_cur.op == OP_OUT_READ);
	assign ram_raddr = (uw_cur.op == OP_BT_READ) ? IDX_W'(col_q - CNT_W'(1))
		: col_q[IDX_W-1:0];

	nqb_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_N)
	) u_placed_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q[IDX_W-1:0]),
		.wdata (trow_q[IDX_W-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: set on emit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((uw_cur.op == OP_EMIT) || (uw_cur.op == OP_EMIT_FAIL)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw_cur.op == OP_EMIT) begin
			out_column_q <= col_q[IDX_W-1:0];
			out_row_q    <= ram_rdata;
			out_found_q  <= 1'b1;
			out_last_q   <= (col_q + CNT_W'(1)) == n_q;
		end else if (uw_cur.op == OP_EMIT_FAIL) begin
			out_column_q <= '0;
			out_row_q    <= '0;
			out_found_q  <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.column    = out_column_q;
	assign result.queen_row = out_row_q;
	assign result.found     = out_found_q;
	assign result.last      = out_last_q;

`ifndef NO_ASSERTIONS
	// an emit never overwrites a beat still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		((uw_cur.op == OP_EMIT) || (uw_cur.op == OP_EMIT_FAIL)) |-> !out_valid_q)
		else $error("emit while output register is occupied");

	// column counter never runs past the board
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= n_q)
		else $error("column counter beyond board size");

	// at the loop head one row is taken per placed column
	a_rows_count: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == S_LOOP) |-> ($countones(rows_q) == 32'(col_q)))
		else $error("row mask out of step with placed columns");

	// a start beat begins the search on an empty board
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start.valid && start.ready && start.start_req) |=>
		((upc_q == S_LOOP) && (rows_q == '0) && (col_q == '0)))
		else $error("search did not start from a clear board");
`endif

endmodule
